// ----- rtl/bsm_pkg.sv -----
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types and constants for the bank switch mapper.
// ----------------------------------------------------------------------------
package bsm_pkg;

    localparam int NUM_BANK_REGS = 8;
    localparam int BANK_IDX_W    = $clog2(NUM_BANK_REGS);
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 8;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_CLOCK = 2'd1,
        MODE_PRG   = 2'd2,
        MODE_CHR   = 2'd3
    } item_mode_t;

    // {address[14:13], address[0]} of a write at 0x8000 and above
    typedef enum logic [2:0] {
        REG_BANK_SELECT = 3'b000,
        REG_BANK_DATA   = 3'b001,
        REG_MIRROR      = 3'b010,
        REG_RAM_PROTECT = 3'b011,
        REG_IRQ_LATCH   = 3'b100,
        REG_IRQ_RELOAD  = 3'b101,
        REG_IRQ_DISABLE = 3'b110,
        REG_IRQ_ENABLE  = 3'b111
    } reg_code_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PRG_MASK    = 2'd0,
        CFG_CHR_MASK    = 2'd1,
        CFG_FOUR_SCREEN = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        MIRROR_VERTICAL   = 2'd0,
        MIRROR_HORIZONTAL = 2'd1,
        MIRROR_FOUR       = 2'd2
    } mirror_t;

    typedef logic [NUM_BANK_REGS-1:0][7:0] bank_regs_t;

    localparam bank_regs_t BANK_REGS_RESET = {
        8'd1, 8'd0, 8'd7, 8'd6, 8'd5, 8'd4, 8'd2, 8'd0
    };

    localparam logic [7:0] PRG_MASK_RESET    = 8'd63;
    localparam logic [7:0] CHR_MASK_RESET    = 8'd255;
    localparam logic [7:0] RAM_PROTECT_RESET = 8'h80;
    localparam logic [7:0] BANK_SECOND_LAST  = 8'hFE;
    localparam logic [7:0] BANK_LAST         = 8'hFF;

    typedef struct packed {
        logic [7:0] prg_mask;
        logic [7:0] chr_mask;
        logic       four_screen;
        logic [7:0] bank_select;
        bank_regs_t bank_regs;
        logic       mirror_h;
        logic [7:0] ram_protect;
        logic       irq_pending;
    } map_view_t;

endpackage

// ----- rtl/bsm_state.sv -----
// ----------------------------------------------------------------------------
// bsm_state
// Mapper registers, scanline counter and configuration; presents the
// state as it stands after the item in the execute stage.
// ----------------------------------------------------------------------------
module bsm_state import bsm_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   upd_en,
    input  item_mode_t             mode,
    input  logic [15:0]            address,
    input  logic [7:0]             value,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output map_view_t              view
);

    logic [7:0] prg_mask_reg, prg_mask_next;
    logic [7:0] chr_mask_reg, chr_mask_next;
    logic       four_screen_reg, four_screen_next;
    logic [7:0] bank_select_reg, bank_select_next;
    bank_regs_t bank_regs_reg, bank_regs_next;
    logic       mirror_h_reg, mirror_h_next;
    logic [7:0] ram_protect_reg, ram_protect_next;
    logic [7:0] irq_latch_reg, irq_latch_next;
    logic [7:0] irq_counter_reg, irq_counter_next;
    logic       irq_enabled_reg, irq_enabled_next;
    logic       irq_pending_reg, irq_pending_next;

    reg_code_t  code;
    logic [7:0] count_step;

    assign code       = reg_code_t'({address[14:13], address[0]});
    assign count_step = (irq_counter_reg == 8'd0) ? irq_latch_reg
                                                  : irq_counter_reg - 8'd1;

    // item effect
    always_comb begin
        bank_select_next = bank_select_reg;
        bank_regs_next   = bank_regs_reg;
        mirror_h_next    = mirror_h_reg;
        ram_protect_next = ram_protect_reg;
        irq_latch_next   = irq_latch_reg;
        irq_counter_next = irq_counter_reg;
        irq_enabled_next = irq_enabled_reg;
        irq_pending_next = irq_pending_reg;
        if (mode == MODE_WRITE && address[15]) begin
            unique case (code)
                REG_BANK_SELECT: bank_select_next = value;
                REG_BANK_DATA:   bank_regs_next[bank_select_reg[BANK_IDX_W-1:0]] = value;
                REG_MIRROR:      mirror_h_next = value[0];
                REG_RAM_PROTECT: ram_protect_next = value;
                REG_IRQ_LATCH:   irq_latch_next = value;
                REG_IRQ_RELOAD:  irq_counter_next = 8'd0;
                REG_IRQ_DISABLE: begin
                    irq_enabled_next = 1'b0;
                    irq_pending_next = 1'b0;
                end
                REG_IRQ_ENABLE:  irq_enabled_next = 1'b1;
                default:         irq_enabled_next = irq_enabled_reg;
            endcase
        end else if (mode == MODE_CLOCK) begin
            irq_counter_next = count_step;
            if (count_step == 8'd0 && irq_enabled_reg) begin
                irq_pending_next = 1'b1;
            end
        end
    end

    always_comb begin
        prg_mask_next    = prg_mask_reg;
        chr_mask_next    = chr_mask_reg;
        four_screen_next = four_screen_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PRG_MASK:    prg_mask_next = cfg_data;
                CFG_CHR_MASK:    chr_mask_next = cfg_data;
                CFG_FOUR_SCREEN: four_screen_next = cfg_data[0];
                default:         four_screen_next = four_screen_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_mask_reg    <= PRG_MASK_RESET;
            chr_mask_reg    <= CHR_MASK_RESET;
            four_screen_reg <= 1'b0;
            bank_select_reg <= 8'd0;
            bank_regs_reg   <= BANK_REGS_RESET;
            mirror_h_reg    <= 1'b0;
            ram_protect_reg <= RAM_PROTECT_RESET;
            irq_latch_reg   <= 8'd0;
            irq_counter_reg <= 8'd0;
            irq_enabled_reg <= 1'b0;
            irq_pending_reg <= 1'b0;
        end else begin
            prg_mask_reg    <= prg_mask_next;
            chr_mask_reg    <= chr_mask_next;
            four_screen_reg <= four_screen_next;
            if (upd_en) begin
                bank_select_reg <= bank_select_next;
                bank_regs_reg   <= bank_regs_next;
                mirror_h_reg    <= mirror_h_next;
                ram_protect_reg <= ram_protect_next;
                irq_latch_reg   <= irq_latch_next;
                irq_counter_reg <= irq_counter_next;
                irq_enabled_reg <= irq_enabled_next;
                irq_pending_reg <= irq_pending_next;
            end
        end
    end

    always_comb begin
        view.prg_mask    = prg_mask_reg;
        view.chr_mask    = chr_mask_reg;
        view.four_screen = four_screen_reg;
        view.bank_select = bank_select_next;
        view.bank_regs   = bank_regs_next;
        view.mirror_h    = mirror_h_next;
        view.ram_protect = ram_protect_next;
        view.irq_pending = irq_pending_next;
    end

    a_pending_from_clock: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(irq_pending_reg) |-> $past(upd_en && mode == MODE_CLOCK))
        else $error("irq pending set without a counter clock");

    a_enable_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(irq_enabled_reg) |-> $past(upd_en && mode == MODE_WRITE && address[15]
                                         && code == REG_IRQ_DISABLE))
        else $error("irq enable cleared without a disable write");

    a_pending_needs_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(irq_pending_reg) |-> $past(irq_enabled_reg))
        else $error("irq pending set while disabled");

endmodule

// ----- rtl/bsm_lookup.sv -----
// ----------------------------------------------------------------------------
// bsm_lookup
// Program and pattern window lookup with bank count masking.
// ----------------------------------------------------------------------------
module bsm_lookup import bsm_pkg::*; (
    input  item_mode_t  mode,
    input  logic [15:0] address,
    input  map_view_t   view,
    output logic [7:0]  bank
);

    logic       swap;
    logic [2:0] slot;
    logic [7:0] prg_raw;
    logic [7:0] chr_raw;

    assign swap = view.bank_select[6];
    assign slot = address[12:10] ^ {view.bank_select[7], 2'b00};

    always_comb begin
        unique case (address[14:13])
            2'd0:    prg_raw = swap ? BANK_SECOND_LAST : view.bank_regs[6];
            2'd1:    prg_raw = view.bank_regs[7];
            2'd2:    prg_raw = swap ? view.bank_regs[6] : BANK_SECOND_LAST;
            default: prg_raw = BANK_LAST;
        endcase
    end

    always_comb begin
        unique case (slot)
            3'd0:    chr_raw = {view.bank_regs[0][7:1], 1'b0};
            3'd1:    chr_raw = {view.bank_regs[0][7:1], 1'b1};
            3'd2:    chr_raw = {view.bank_regs[1][7:1], 1'b0};
            3'd3:    chr_raw = {view.bank_regs[1][7:1], 1'b1};
            3'd4:    chr_raw = view.bank_regs[2];
            3'd5:    chr_raw = view.bank_regs[3];
            3'd6:    chr_raw = view.bank_regs[4];
            default: chr_raw = view.bank_regs[5];
        endcase
    end

    always_comb begin
        bank = 8'd0;
        if (mode == MODE_PRG && address[15]) begin
            bank = prg_raw & view.prg_mask;
        end else if (mode == MODE_CHR && address[15:13] == 3'd0) begin
            bank = chr_raw & view.chr_mask;
        end
    end

endmodule

// ----- rtl/bank_switch_mapper_scanline_irq_top.sv -----
// ----------------------------------------------------------------------------
// bank_switch_mapper_scanline_irq_top
// Bank switching mapper with scanline interrupt counter, one result per item.
//
//   channel   dir  tdata                                  tuser
//   s_        in   address[15:0] value[23:16]             mode[1:0]
//   m_        out  bank[7:0] irq_line[8] mirror_mode[10:9]  -
//                  ram_enable[11] ram_write_enable[12]
//   cfg_      in   write port, index 0..2, 8-bit data
//
// One transfer per cycle sustained while m_ is not stalled; a result passes
// through the input register, then the result register, before it leaves.
// The execute step between those registers applies the item to the mapper
// state and does the window lookup in the same cycle.
// Reset clears the valid flags and loads the mapper state and the configuration with their reset values.
// A stall on m_ holds the result register; s_ keeps taking items until
// the input register is also full.
// ----------------------------------------------------------------------------
module bank_switch_mapper_scanline_irq_top import bsm_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [23:0]            s_tdata,   // address[15:0], value[23:16]
    input  logic [1:0]             s_tuser,   // mode[1:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [15:0]            m_tdata,   // bank[7:0], irq_line[8], mirror_mode[10:9],
                                              // ram_enable[11], ram_write_enable[12], zero
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic        in_valid_reg, in_valid_next;
    item_mode_t  in_mode_reg;
    logic [15:0] in_addr_reg;
    logic [7:0]  in_value_reg;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_data_reg, out_data_next;

    logic        advance;
    logic        s_fire;
    logic        upd_en;
    map_view_t   view;
    logic [7:0]  bank;
    mirror_t     mirror;
    logic        ram_en;
    logic        ram_wr_en;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;
    assign upd_en   = in_valid_reg && advance;

    bsm_state u_state (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .upd_en    (upd_en),
        .mode      (in_mode_reg),
        .address   (in_addr_reg),
        .value     (in_value_reg),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .view      (view)
    );

    bsm_lookup u_lookup (
        .mode    (in_mode_reg),
        .address (in_addr_reg),
        .view    (view),
        .bank    (bank)
    );

    assign mirror    = view.four_screen ? MIRROR_FOUR :
                       (view.mirror_h ? MIRROR_HORIZONTAL : MIRROR_VERTICAL);
    assign ram_en    = view.ram_protect[7];
    assign ram_wr_en = view.ram_protect[7] && !view.ram_protect[6];

    always_comb begin
        in_valid_next  = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
        out_data_next  = {3'b000, ram_wr_en, ram_en, mirror, view.irq_pending, bank};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_mode_reg  <= item_mode_t'(s_tuser);
            in_addr_reg  <= s_tdata[15:0];
            in_value_reg <= s_tdata[23:16];
        end
        if (upd_en) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_out_from_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(in_valid_reg))
        else $error("result without an item in the execute stage");

    a_ram_enables: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[12] && !m_tdata[11]))
        else $error("ram write enable without ram enable");

    a_mirror_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[10:9] != 2'd3)
        else $error("illegal mirroring code");

endmodule

// ----- tb/tb_bank_switch_mapper_scanline_irq_top.sv -----
// ----------------------------------------------------------------------------
// tb_bank_switch_mapper_scanline_irq_top
// Self-checking bench for the bank switch mapper. A local model of the
// mapper state predicts each result: register writes, counter clocks and
// window lookups, under several bank mask and four-screen settings. The
// sender idles in random bursts, the receiver stalls on its own pattern,
// and one long output hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module tb_bank_switch_mapper_scanline_irq_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bsm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    // bank[7:0], irq_line[8], mirror_mode[10:9], ram_enable[11], ram_write_enable[12]
    typedef struct packed {
        logic       ram_we;
        logic       ram_en;
        mirror_t    mirror;
        logic       irq_line;
        logic [7:0] bank;
    } map_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata   = '0;
    logic [1:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;
    logic                  cfg_wr_en = 1'b0;
    cfg_index_t            cfg_index = CFG_PRG_MASK;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // mapper model state
    logic [7:0] cfg_prg_mask;
    logic [7:0] cfg_chr_mask;
    logic       cfg_four;
    logic [7:0] bank_sel;
    bank_regs_t bank_file;
    logic       mirror_h;
    logic [7:0] prot_byte;
    logic [7:0] irq_reload_val;
    logic [7:0] irq_count;
    logic       irq_armed;
    logic       irq_flag;

    map_result_t map_results_due[$];

    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          burst_left     = 0;
    bit          tx_gaps_on     = 1'b1;
    bit          rx_stall_on    = 1'b0;
    int          hold_req_count = 0;
    int          hold_seen      = 0;
    int          hold_cnt       = 0;
    logic [15:0] rx_pattern     = 16'hA5F3;

    always #10 aclk = ~aclk;

    bank_switch_mapper_scanline_irq_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic void reset_map_model();
        cfg_prg_mask   = PRG_MASK_RESET;
        cfg_chr_mask   = CHR_MASK_RESET;
        cfg_four       = 1'b0;
        bank_sel       = '0;
        bank_file      = BANK_REGS_RESET;
        mirror_h       = 1'b0;
        prot_byte      = RAM_PROTECT_RESET;
        irq_reload_val = '0;
        irq_count      = '0;
        irq_armed      = 1'b0;
        irq_flag       = 1'b0;
    endfunction

    function automatic map_result_t predict_map_result(item_mode_t mode, logic [15:0] addr,
                                                       logic [7:0] val);
        map_result_t r;
        logic [7:0]  b;
        logic [2:0]  slot;
        b = '0;
        case (mode)
            MODE_WRITE: begin
                if (addr[15]) begin
                    case (reg_code_t'({addr[14:13], addr[0]}))
                        REG_BANK_SELECT: bank_sel = val;
                        REG_BANK_DATA:   bank_file[bank_sel[BANK_IDX_W-1:0]] = val;
                        REG_MIRROR:      mirror_h = val[0];
                        REG_RAM_PROTECT: prot_byte = val;
                        REG_IRQ_LATCH:   irq_reload_val = val;
                        REG_IRQ_RELOAD:  irq_count = '0;
                        REG_IRQ_DISABLE: begin
                            irq_armed = 1'b0;
                            irq_flag  = 1'b0;
                        end
                        default:         irq_armed = 1'b1;
                    endcase
                end
            end
            MODE_CLOCK: begin
                if (irq_count == 8'd0)
                    irq_count = irq_reload_val;
                else
                    irq_count = irq_count - 8'd1;
                if (irq_count == 8'd0 && irq_armed)
                    irq_flag = 1'b1;
            end
            MODE_PRG: begin
                if (addr[15]) begin
                    case (addr[14:13])
                        2'd0:    b = bank_sel[6] ? BANK_SECOND_LAST : bank_file[6];
                        2'd1:    b = bank_file[7];
                        2'd2:    b = bank_sel[6] ? bank_file[6] : BANK_SECOND_LAST;
                        default: b = BANK_LAST;
                    endcase
                    b = b & cfg_prg_mask;
                end
            end
            default: begin
                if (addr[15:13] == 3'd0) begin
                    slot = addr[12:10] ^ {bank_sel[7], 2'b00};
                    case (slot)
                        3'd0:    b = bank_file[0] & 8'hFE;
                        3'd1:    b = bank_file[0] | 8'h01;
                        3'd2:    b = bank_file[1] & 8'hFE;
                        3'd3:    b = bank_file[1] | 8'h01;
                        default: b = bank_file[slot - 3'd2];
                    endcase
                    b = b & cfg_chr_mask;
                end
            end
        endcase
        r.bank     = b;
        r.irq_line = irq_flag;
        r.mirror   = cfg_four ? MIRROR_FOUR : (mirror_h ? MIRROR_HORIZONTAL : MIRROR_VERTICAL);
        r.ram_en   = prot_byte[7];
        r.ram_we   = prot_byte[7] & ~prot_byte[6];
        return r;
    endfunction

    // config, result check and prediction, all on sampled values
    always @(posedge aclk) begin
        map_result_t got;
        map_result_t want;
        if (aresetn) begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_PRG_MASK:    cfg_prg_mask = cfg_data;
                    CFG_CHR_MASK:    cfg_chr_mask = cfg_data;
                    CFG_FOUR_SCREEN: cfg_four = cfg_data[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = map_result_t'(m_tdata[12:0]);
                if (map_results_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result transfer: tdata %h", m_tdata);
                end else begin
                    want = map_results_due.pop_front();
                    if (got.bank !== want.bank || got.irq_line !== want.irq_line ||
                        got.mirror !== want.mirror || got.ram_en !== want.ram_en ||
                        got.ram_we !== want.ram_we) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: exp bank %0d irq %0d mirror %0d ram_en %0d ",
                                      "ram_we %0d, got bank %0d irq %0d mirror %0d ram_en %0d ",
                                      "ram_we %0d"},
                                     want.bank, want.irq_line, want.mirror, want.ram_en,
                                     want.ram_we, got.bank, got.irq_line, got.mirror,
                                     got.ram_en, got.ram_we);
                    end
                end
            end
            if (s_tvalid && s_tready)
                map_results_due.push_back(predict_map_result(item_mode_t'(s_tuser),
                                                             s_tdata[15:0], s_tdata[23:16]));
        end
    end

    // receiver: long hold-off on request, else always ready or, with stalls on, a rotating stall pattern
    always @(posedge aclk) begin
        logic [15:0] pat;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_seen != hold_req_count) begin
            hold_seen <= hold_req_count;
            hold_cnt  <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else if (!rx_stall_on) begin
            m_tready <= 1'b1;
        end else begin
            pat = ($urandom_range(0, 47) == 0) ? (16'($urandom) | 16'h0001) : rx_pattern;
            m_tready   <= pat[0];
            rx_pattern <= {pat[0], pat[15:1]};
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_item(item_mode_t mode, logic [15:0] addr, logic [7:0] val);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = tx_gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {val, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (map_results_due.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(cfg_index_t idx, logic [7:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(logic [7:0] prg_mask, logic [7:0] chr_mask, logic four);
        wait_all_results();
        cfg_write(CFG_PRG_MASK, prg_mask);
        cfg_write(CFG_CHR_MASK, chr_mask);
        cfg_write(CFG_FOUR_SCREEN, {7'd0, four});
    endtask

    // register address with random don't-care bits
    function automatic logic [15:0] reg_addr(reg_code_t code);
        return {1'b1, code[2:1], 12'($urandom), code[0]};
    endfunction

    task automatic send_random_item();
        int          pick;
        logic [15:0] addr;
        logic [7:0]  val;
        pick = $urandom_range(0, 99);
        addr = 16'($urandom);
        val  = 8'($urandom);
        if (pick < 35) begin
            if ($urandom_range(0, 9) != 0)
                addr[15] = 1'b1;
            if (reg_code_t'({addr[14:13], addr[0]}) == REG_IRQ_LATCH && $urandom_range(0, 1))
                val = 8'($urandom_range(0, 6));
            send_item(MODE_WRITE, addr, val);
        end else if (pick < 55) begin
            send_item(MODE_CLOCK, addr, val);
        end else if (pick < 75) begin
            if ($urandom_range(0, 4) != 0)
                addr[15] = 1'b1;
            send_item(MODE_PRG, addr, val);
        end else begin
            if ($urandom_range(0, 4) != 0)
                addr[15:13] = 3'd0;
            send_item(MODE_CHR, addr, val);
        end
    endtask

    task automatic test_directed_cases();
        send_item(MODE_PRG, 16'h0000, 8'h00);
        send_item(MODE_PRG, 16'h8000, 8'hFF);
        send_item(MODE_PRG, 16'hA000, 8'h00);
        send_item(MODE_PRG, 16'hC000, 8'h00);
        send_item(MODE_CHR, 16'h0000, 8'h00);
        send_item(MODE_CHR, 16'h1FFF, 8'h00);
        send_item(MODE_CHR, 16'h2000, 8'h00);
        send_item(MODE_CHR, 16'hFFFF, 8'hFF);
        send_item(MODE_WRITE, 16'h7FFF, 8'hFF);
        send_item(MODE_WRITE, 16'h8000, 8'hC7);
        send_item(MODE_WRITE, 16'h8001, 8'hFF);
        send_item(MODE_PRG, 16'h8000, 8'h00);
        send_item(MODE_PRG, 16'hA000, 8'h00);
        send_item(MODE_PRG, 16'hFFFF, 8'h00);
        send_item(MODE_CHR, 16'h0000, 8'h00);
        send_item(MODE_CHR, 16'h1000, 8'h00);
        send_item(MODE_WRITE, 16'hA000, 8'hFF);
        send_item(MODE_WRITE, 16'hA001, 8'h40);
        send_item(MODE_WRITE, 16'hA001, 8'h80);
        send_item(MODE_WRITE, 16'hC000, 8'h01);
        send_item(MODE_WRITE, 16'hC001, 8'h00);
        send_item(MODE_WRITE, 16'hE001, 8'h00);
        send_item(MODE_CLOCK, 16'h0000, 8'h00);
        send_item(MODE_CLOCK, 16'hFFFF, 8'hFF);
        send_item(MODE_WRITE, 16'hE000, 8'h00);
        wait_all_results();
    endtask

    task automatic test_irq_sequences();
        int n;
        repeat (8) begin
            n = $urandom_range(0, 5);
            send_item(MODE_WRITE, reg_addr(REG_IRQ_LATCH), 8'(n));
            send_item(MODE_WRITE, reg_addr(REG_IRQ_RELOAD), 8'($urandom));
            if ($urandom_range(0, 3) != 0)
                send_item(MODE_WRITE, reg_addr(REG_IRQ_ENABLE), 8'($urandom));
            repeat (n + 3) begin
                if ($urandom_range(0, 2) == 0)
                    send_random_item();
                else
                    send_item(MODE_CLOCK, 16'($urandom), 8'($urandom));
            end
            if ($urandom_range(0, 1))
                send_item(MODE_WRITE, reg_addr(REG_IRQ_DISABLE), 8'($urandom));
        end
        wait_all_results();
    endtask

    task automatic test_config_sweep();
        set_config(8'd0, 8'd0, 1'b0);
        repeat (55) send_random_item();
        set_config(8'd255, 8'd255, 1'b1);
        repeat (55) send_random_item();
        set_config(8'd1, 8'd3, 1'b0);
        repeat (55) send_random_item();
        set_config(8'd127, 8'd7, 1'b1);
        repeat (55) send_random_item();
        set_config(8'd15, 8'd255, 1'b0);
        repeat (55) send_random_item();
        set_config(PRG_MASK_RESET, CHR_MASK_RESET, 1'b0);
        repeat (55) send_random_item();
        wait_all_results();
    endtask

    task automatic test_backpressure();
        wait_all_results();
        tx_gaps_on = 1'b0;
        hold_req_count <= hold_req_count + 1;
        repeat (40) send_random_item();
        tx_gaps_on = 1'b1;
        wait_all_results();
    endtask

    task automatic test_random_mix();
        for (int i = 0; i < 350; i++) begin
            if (i % 50 == 0) begin
                rx_stall_on <= (i % 100 == 0);
                tx_gaps_on = (i % 150 != 0);
            end
            send_random_item();
        end
        rx_stall_on <= 1'b1;
        tx_gaps_on = 1'b1;
        wait_all_results();
    endtask

    initial begin
        reset_map_model();
        repeat (6) @(posedge aclk);
        aresetn     <= 1'b1;
        rx_stall_on <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_irq_sequences();
        test_config_sweep();
        test_backpressure();
        test_random_mix();
        wait_all_results();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && map_results_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
